// ===== hdl/json_stream_validator_assert.svh =====
// Assertion helpers for the stream validator.
`ifndef JSON_STREAM_VALIDATOR_ASSERT_SVH
`define JSON_STREAM_VALIDATOR_ASSERT_SVH

// Plain invariant, checked on every rising clock edge outside reset.
`define JSV_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define JSV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/jsv_pkg.sv =====
`default_nettype none
package jsv_pkg;

    localparam logic [3:0] EV_OBJ_OPEN  = 4'd0;
    localparam logic [3:0] EV_OBJ_CLOSE = 4'd1;
    localparam logic [3:0] EV_ARR_OPEN  = 4'd2;
    localparam logic [3:0] EV_ARR_CLOSE = 4'd3;
    localparam logic [3:0] EV_KEY_CHAR  = 4'd4;
    localparam logic [3:0] EV_KEY_END   = 4'd5;
    localparam logic [3:0] EV_STR_CHAR  = 4'd6;
    localparam logic [3:0] EV_STR_END   = 4'd7;
    localparam logic [3:0] EV_INT       = 4'd8;
    localparam logic [3:0] EV_TRUE      = 4'd9;
    localparam logic [3:0] EV_FALSE     = 4'd10;
    localparam logic [3:0] EV_FLOAT_END = 4'd11;
    localparam logic [3:0] EV_DOC_END   = 4'd12;
    localparam logic [3:0] EV_ERROR     = 4'd14;

    localparam logic [3:0] ERR_EMPTY     = 4'd0;
    localparam logic [3:0] ERR_TRAILING  = 4'd1;
    localparam logic [3:0] ERR_COMMENT   = 4'd2;
    localparam logic [3:0] ERR_COLON     = 4'd3;
    localparam logic [3:0] ERR_NULL      = 4'd4;
    localparam logic [3:0] ERR_VALUE     = 4'd5;
    localparam logic [3:0] ERR_KEY       = 4'd6;
    localparam logic [3:0] ERR_OBJ_SEP   = 4'd7;
    localparam logic [3:0] ERR_ARR_SEP   = 4'd8;
    localparam logic [3:0] ERR_UNTERM    = 4'd9;
    localparam logic [3:0] ERR_ESCAPE    = 4'd10;
    localparam logic [3:0] ERR_UNICODE   = 4'd11;
    localparam logic [3:0] ERR_CONTROL   = 4'd12;
    localparam logic [3:0] ERR_NUMBER    = 4'd13;
    localparam logic [3:0] ERR_RANGE     = 4'd14;
    localparam logic [3:0] ERR_DEPTH     = 4'd15;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    typedef enum logic [20:0] {
        PH_DOC_START    = 21'h000001,
        PH_VALUE        = 21'h000002,
        PH_ARR_FIRST    = 21'h000004,
        PH_OBJ_FIRST    = 21'h000008,
        PH_OBJ_KEY      = 21'h000010,
        PH_COLON        = 21'h000020,
        PH_AFTER        = 21'h000040,
        PH_STRING       = 21'h000080,
        PH_ESCAPE       = 21'h000100,
        PH_LIT_T        = 21'h000200,
        PH_LIT_F        = 21'h000400,
        PH_LIT_N        = 21'h000800,
        PH_NUM_SIGN     = 21'h001000,
        PH_NUM_ZERO     = 21'h002000,
        PH_NUM_INT      = 21'h004000,
        PH_NUM_DOT      = 21'h008000,
        PH_NUM_FRAC     = 21'h010000,
        PH_NUM_EXP      = 21'h020000,
        PH_NUM_EXP_SIGN = 21'h040000,
        PH_NUM_EXP_DIG  = 21'h080000,
        PH_STOPPED      = 21'h100000
    } t_phase;

    typedef enum logic [4:0] {
        CM_NONE  = 5'b00001,
        CM_SLASH = 5'b00010,
        CM_LINE  = 5'b00100,
        CM_BLOCK = 5'b01000,
        CM_STAR  = 5'b10000
    } t_cmode;

    typedef struct packed {
        logic [3:0]  ev;
        logic [7:0]  ch;
        logic [31:0] ival;
        logic [3:0]  err;
        logic [31:0] col;
        logic [6:0]  dep;
        logic        last;
    } t_res;

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (kind)
            LIT_TRUE: begin
                unique case (idx)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                unique case (idx)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            LIT_NULL: begin
                unique case (idx)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/json_stream_validator.sv =====
`default_nettype none
// Streaming JSON tokenizer and validator.
// Input stream (s_*): one transfer per document byte; s_tdata is the byte and
// s_tuser set (or a zero byte) marks end of text, which closes the document.
// Output stream (m_*): one transfer per token event; m_tlast marks the final
// event caused by one input transfer. Each byte yields zero, one or two events.
// Throughput: one input byte per clock. Every byte is decoded in the cycle it
// is taken and its events land in a four-entry registered result queue, read
// out on m_* from the cycle after the input transfer. s_tready drops only
// while the queue holds more than two events, i.e. when the receiver stalls
// or a run of two-event bytes outpaces the one-event-per-cycle output.
// The open-container stack is a memory with a prefetched entry under the top,
// so neither a push nor a pop waits on a stack read.
// APB register 0 (ignore_comments) must be written only while the block is idle;
// the block does not enforce this. Reset clears the parser to document start,
// empties the queue and clears ignore_comments. The first error emits one error
// event and the rest of the document is dropped until end of text.
module json_stream_validator #(
    parameter int MAX_DEPTH   = 64,
    parameter int COLUMN_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tuser,   // [0] action
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [3:0] event_res, [11:4] char_value,
                                        // [43:12] int_value, [47:44] error_code,
                                        // [79:48] column, [86:80] nest_depth, [87] 0
    output logic             m_tlast    // last
);
    import jsv_pkg::*;

    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    logic          r_ign;
    logic          w_acc;
    t_res          w_res0, w_res1;
    logic [1:0]    w_nres;
    t_res          r_q [QD];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt, n_cnt;
    logic          w_pop;
    t_res          w_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_ign} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ign <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_ign <= pwdata[0];
        end
    end

    assign s_tready = (r_cnt <= (QW+1)'(QD - 2));
    assign w_acc    = s_tvalid && s_tready;

    jsv_parse #(
        .MAX_DEPTH  (MAX_DEPTH),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_action(s_tuser),
        .i_byte  (s_tdata),
        .i_ign   (r_ign),
        .o_res0  (w_res0),
        .o_res1  (w_res1),
        .o_nres  (w_nres)
    );

    assign w_head   = r_q[r_rp];
    assign m_tvalid = (r_cnt != '0);
    assign w_pop    = m_tvalid && m_tready;
    assign m_tdata  = {1'b0, w_head.dep, w_head.col, w_head.err, w_head.ival,
                       w_head.ch, w_head.ev};
    assign m_tlast  = w_head.last;

    assign n_cnt = r_cnt + (QW+1)'(w_nres) - (QW+1)'(w_pop);

    always_ff @(posedge i_clk) begin
        if (w_nres != 2'd0) r_q[r_wp] <= w_res0;
        if (w_nres == 2'd2) r_q[r_wp + 1'b1] <= w_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QW'(w_nres);
            r_rp  <= r_rp + QW'(w_pop);
            r_cnt <= n_cnt;
        end
    end

`include "json_stream_validator_assert.svh"

    `JSV_ASSERT(a_queue_bound, r_cnt <= (QW+1)'(QD), "result queue overflow")
    `JSV_ASSERT_IMP(a_idle_parse, !w_acc, w_nres == 2'd0, "results without a transfer")
    `JSV_ASSERT_IMP(a_one_last, w_nres == 2'd1, w_res0.last, "single result not marked last")
    `JSV_ASSERT_IMP(a_two_last, w_nres == 2'd2, !w_res0.last && w_res1.last, "bad last marking")

endmodule
`default_nettype wire

// ===== hdl/jsv_parse.sv =====
`default_nettype none
module jsv_parse #(
    parameter int MAX_DEPTH   = 64,
    parameter int COLUMN_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_acc,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_ign,
    output jsv_pkg::t_res    o_res0,
    output jsv_pkg::t_res    o_res1,
    output logic [1:0]       o_nres
);
    import jsv_pkg::*;

    localparam int CB = COLUMN_BITS;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    t_phase          r_ph, n_ph;
    t_cmode          r_cm, n_cm;
    logic [DW-1:0]   r_dep, n_dep;
    logic [32:0]     r_acc, n_acc;
    logic            r_neg, n_neg;
    logic [2:0]      r_li, n_li;
    logic [CB-1:0]   r_bpos, n_bpos;
    logic [CB-1:0]   r_tcol, n_tcol;
    logic            r_inkey, n_inkey;
    logic            r_top, n_top;
    logic            r_below;
    logic            n_push;
    logic            n_kind;
    t_res            n_res0, n_res1;
    logic [1:0]      n_cnt;

    // container kinds, 1 = object
    logic            r_stack [MAX_DEPTH];
    logic [DW-1:0]   w_rd_dep;

    function automatic logic [CB-1:0] sinc(input logic [CB-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    function automatic logic [31:0] sat32(input logic [CB-1:0] x);
        logic [CB+31:0] w;
        w = {32'd0, x};
        return (|w[CB+31:32]) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic t_res mk(input logic [3:0] ev, input logic [7:0] ch,
                                input logic [31:0] iv, input logic [3:0] er,
                                input logic [CB-1:0] c, input logic [DW-1:0] d);
        t_res r;
        logic [DW+6:0] dw;
        dw     = {7'd0, d};
        r.ev   = ev;
        r.ch   = ch;
        r.ival = iv;
        r.err  = er;
        r.col  = sat32(c);
        r.dep  = dw[6:0];
        r.last = 1'b0;
        return r;
    endfunction

    always_comb begin : p_next
        t_phase        ph;
        t_cmode        cm;
        logic [DW-1:0] dep;
        logic [32:0]   acc;
        logic          neg;
        logic [2:0]    li;
        logic [CB-1:0] bpos;
        logic [CB-1:0] tcol;
        logic [CB-1:0] ccol;
        logic [CB-1:0] tc;
        logic [CB-1:0] fc;
        logic [3:0]    fe;
        logic          inkey;
        logic          top;
        logic          eot;
        logic          fin_go;
        logic          ws_go;
        logic          tok_go;
        logic          endp_go;
        logic          sv_go;
        logic          pop_go;
        logic          kind;
        logic          isdig;
        logic [7:0]    b;
        logic [7:0]    tb;
        logic [7:0]    ec;
        logic [3:0]    dv;
        logic [36:0]   prod;
        logic [32:0]   lim;
        logic [32:0]   negv;
        logic [1:0]    lk;
        logic [2:0]    nidx;
        t_res          rs [2];
        logic [1:0]    n;

        ph = r_ph; cm = r_cm; dep = r_dep; acc = r_acc; neg = r_neg; li = r_li;
        bpos = r_bpos; tcol = r_tcol; inkey = r_inkey; top = r_top;
        b = i_byte;
        eot = i_action || (i_byte == 8'h00);
        fin_go = 1'b0; ws_go = 1'b0; tok_go = 1'b0; endp_go = 1'b0;
        sv_go = 1'b0; pop_go = 1'b0; kind = 1'b0;
        tb = 8'h00; tc = '0; fc = '0; fe = ERR_EMPTY; ec = 8'h00;
        isdig = (b >= "0") && (b <= "9");
        dv = b[3:0];
        prod = '0; lim = '0; negv = '0; lk = LIT_TRUE; nidx = '0;
        rs[0] = '0; rs[1] = '0; n = 2'd0;
        n_push = 1'b0; n_kind = 1'b0;

        if (eot) begin
            ccol = sinc(r_bpos);
            if (ph != PH_STOPPED) begin
                if (cm == CM_SLASH) begin
                    cm = CM_NONE; tok_go = 1'b1; tb = "/"; tc = r_tcol;
                end else if (cm == CM_BLOCK || cm == CM_STAR) begin
                    ph = PH_STOPPED; fe = ERR_COMMENT; fc = ccol;
                end else begin
                    cm = CM_NONE;
                end
                fin_go = 1'b1;
                endp_go = 1'b1;
            end
        end else begin
            bpos = sinc(r_bpos);
            ccol = bpos;
            if (ph == PH_STOPPED) begin
                // document already failed: drop the byte
            end else if (cm != CM_NONE) begin
                unique case (cm)
                    CM_SLASH: begin
                        if (b == "/") cm = CM_LINE;
                        else if (b == "*") cm = CM_BLOCK;
                        else begin
                            cm = CM_NONE; tok_go = 1'b1; tb = "/"; tc = r_tcol;
                        end
                    end
                    CM_LINE:  if (b == 8'h0A) cm = CM_NONE;
                    CM_BLOCK: if (b == "*") cm = CM_STAR;
                    CM_STAR: begin
                        if (b == "/") cm = CM_NONE;
                        else if (b != "*") cm = CM_BLOCK;
                    end
                    default: cm = CM_NONE;
                endcase
            end else if (ph == PH_ESCAPE) begin
                unique case (b)
                    8'h22: ec = 8'h22;
                    8'h5C: ec = 8'h5C;
                    8'h2F: ec = 8'h2F;
                    "b":   ec = 8'h08;
                    "f":   ec = 8'h0C;
                    "n":   ec = 8'h0A;
                    "r":   ec = 8'h0D;
                    "t":   ec = 8'h09;
                    default: ec = 8'h00;
                endcase
                if (b == "u") begin
                    ph = PH_STOPPED; fe = ERR_UNICODE; fc = sinc(ccol);
                end else if (ec == 8'h00) begin
                    ph = PH_STOPPED; fe = ERR_ESCAPE; fc = sinc(ccol);
                end else begin
                    rs[n[0]] = mk(inkey ? EV_KEY_CHAR : EV_STR_CHAR, ec, 32'd0,
                                  ERR_EMPTY, ccol, dep);
                    n = n + 2'd1;
                    ph = PH_STRING;
                end
            end else if (ph == PH_STRING) begin
                if (b == 8'h22) begin
                    rs[n[0]] = mk(inkey ? EV_KEY_END : EV_STR_END, 8'h00, 32'd0,
                                  ERR_EMPTY, ccol, dep);
                    n = n + 2'd1;
                    ph = inkey ? PH_COLON : PH_AFTER;
                end else if (b == 8'h5C) begin
                    ph = PH_ESCAPE;
                end else if (b < CTRL_LIMIT) begin
                    ph = PH_STOPPED; fe = ERR_CONTROL; fc = sinc(ccol);
                end else begin
                    rs[n[0]] = mk(inkey ? EV_KEY_CHAR : EV_STR_CHAR, b, 32'd0,
                                  ERR_EMPTY, ccol, dep);
                    n = n + 2'd1;
                end
            end else if (ph inside {PH_LIT_T, PH_LIT_F, PH_LIT_N}) begin
                lk = (ph == PH_LIT_T) ? LIT_TRUE : (ph == PH_LIT_F) ? LIT_FALSE : LIT_NULL;
                if (li >= lit_len(lk) || b != lit_char(lk, li)) begin
                    ph = PH_STOPPED; fe = ERR_VALUE; fc = r_tcol;
                end else begin
                    nidx = li + 3'd1;
                    li = nidx;
                    if (nidx == lit_len(lk)) begin
                        if (lk == LIT_NULL) begin
                            ph = PH_STOPPED; fe = ERR_NULL; fc = r_tcol;
                        end else begin
                            rs[n[0]] = mk((lk == LIT_TRUE) ? EV_TRUE : EV_FALSE, 8'h00,
                                          32'd0, ERR_EMPTY, ccol, dep);
                            n = n + 2'd1;
                            ph = PH_AFTER;
                        end
                    end
                end
            end else if (ph inside {PH_NUM_SIGN, PH_NUM_ZERO, PH_NUM_INT, PH_NUM_DOT,
                                    PH_NUM_FRAC, PH_NUM_EXP, PH_NUM_EXP_SIGN,
                                    PH_NUM_EXP_DIG}) begin
                unique case (ph)
                    PH_NUM_SIGN: begin
                        if (b == "0") ph = PH_NUM_ZERO;
                        else if (isdig) begin
                            acc = {29'd0, dv}; ph = PH_NUM_INT;
                        end else begin
                            ph = PH_STOPPED; fe = ERR_NUMBER; fc = ccol;
                        end
                    end
                    PH_NUM_ZERO, PH_NUM_INT: begin
                        if (isdig) begin
                            if (ph == PH_NUM_ZERO) begin
                                ph = PH_STOPPED; fe = ERR_NUMBER; fc = ccol;
                            end else begin
                                prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {33'd0, dv};
                                // clamp at 2^32, above the int32 range
                                acc = (prod > 37'h1_0000_0000) ? 33'h1_0000_0000 : prod[32:0];
                            end
                        end else if (b == ".") ph = PH_NUM_DOT;
                        else if (b == "e" || b == "E") ph = PH_NUM_EXP;
                        else begin
                            fin_go = 1'b1; ws_go = 1'b1;
                        end
                    end
                    PH_NUM_DOT: begin
                        if (isdig) ph = PH_NUM_FRAC;
                        else begin
                            ph = PH_STOPPED; fe = ERR_NUMBER; fc = ccol;
                        end
                    end
                    PH_NUM_FRAC: begin
                        if (b == "e" || b == "E") ph = PH_NUM_EXP;
                        else if (!isdig) begin
                            fin_go = 1'b1; ws_go = 1'b1;
                        end
                    end
                    PH_NUM_EXP: begin
                        if (b == "+" || b == "-") ph = PH_NUM_EXP_SIGN;
                        else if (isdig) ph = PH_NUM_EXP_DIG;
                        else begin
                            ph = PH_STOPPED; fe = ERR_NUMBER; fc = ccol;
                        end
                    end
                    PH_NUM_EXP_SIGN: begin
                        if (isdig) ph = PH_NUM_EXP_DIG;
                        else begin
                            ph = PH_STOPPED; fe = ERR_NUMBER; fc = ccol;
                        end
                    end
                    default: begin
                        if (!isdig) begin
                            fin_go = 1'b1; ws_go = 1'b1;
                        end
                    end
                endcase
            end else begin
                ws_go = 1'b1;
            end
        end

        // close a pending number
        if (fin_go && ph != PH_STOPPED) begin
            unique case (ph)
                PH_NUM_ZERO, PH_NUM_INT: begin
                    lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
                    if (acc > lim) begin
                        ph = PH_STOPPED; fe = ERR_RANGE; fc = ccol;
                    end else begin
                        negv = 33'd0 - acc;
                        rs[n[0]] = mk(EV_INT, 8'h00, neg ? negv[31:0] : acc[31:0],
                                      ERR_EMPTY, ccol, dep);
                        n = n + 2'd1;
                        ph = PH_AFTER;
                    end
                end
                PH_NUM_FRAC, PH_NUM_EXP_DIG: begin
                    rs[n[0]] = mk(EV_FLOAT_END, 8'h00, 32'd0, ERR_EMPTY, ccol, dep);
                    n = n + 2'd1;
                    ph = PH_AFTER;
                end
                PH_NUM_SIGN, PH_NUM_DOT, PH_NUM_EXP, PH_NUM_EXP_SIGN: begin
                    ph = PH_STOPPED; fe = ERR_NUMBER; fc = ccol;
                end
                default: ;
            endcase
        end

        // whitespace and comment start
        if (ws_go && ph != PH_STOPPED) begin
            if ((b >= 8'h09 && b <= 8'h0D) || b == 8'h20) begin
                // skip
            end else if (b == "/" && i_ign) begin
                cm = CM_SLASH; tcol = ccol;
            end else begin
                tok_go = 1'b1; tb = b; tc = ccol;
            end
        end

        // structural token
        if (tok_go && ph != PH_STOPPED) begin
            unique case (ph)
                PH_DOC_START, PH_VALUE: sv_go = 1'b1;
                PH_ARR_FIRST: begin
                    if (tb == "]") pop_go = 1'b1;
                    else sv_go = 1'b1;
                end
                PH_OBJ_FIRST: begin
                    if (tb == "}") pop_go = 1'b1;
                    else if (tb == 8'h22) begin
                        inkey = 1'b1; ph = PH_STRING;
                    end else begin
                        ph = PH_STOPPED; fe = ERR_KEY; fc = tc;
                    end
                end
                PH_OBJ_KEY: begin
                    if (tb == 8'h22) begin
                        inkey = 1'b1; ph = PH_STRING;
                    end else begin
                        ph = PH_STOPPED; fe = ERR_KEY; fc = tc;
                    end
                end
                PH_COLON: begin
                    if (tb == ":") ph = PH_VALUE;
                    else begin
                        ph = PH_STOPPED; fe = ERR_COLON; fc = sinc(tc);
                    end
                end
                PH_AFTER: begin
                    if (dep == '0) begin
                        ph = PH_STOPPED; fe = ERR_TRAILING; fc = tc;
                    end else if (top) begin
                        if (tb == "}") pop_go = 1'b1;
                        else if (tb == ",") ph = PH_OBJ_KEY;
                        else begin
                            ph = PH_STOPPED; fe = ERR_OBJ_SEP; fc = sinc(tc);
                        end
                    end else begin
                        if (tb == "]") pop_go = 1'b1;
                        else if (tb == ",") ph = PH_VALUE;
                        else begin
                            ph = PH_STOPPED; fe = ERR_ARR_SEP; fc = sinc(tc);
                        end
                    end
                end
                default: ;
            endcase

            if (sv_go) begin
                if (tb == "{" || tb == "[") begin
                    kind = (tb == "{");
                    if (dep >= DW'(MAX_DEPTH)) begin
                        ph = PH_STOPPED; fe = ERR_DEPTH; fc = tc;
                    end else begin
                        n_push = 1'b1; n_kind = kind;
                        dep = dep + 1'b1;
                        top = kind;
                        rs[n[0]] = mk(kind ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h00, 32'd0,
                                      ERR_EMPTY, ccol, dep);
                        n = n + 2'd1;
                        ph = kind ? PH_OBJ_FIRST : PH_ARR_FIRST;
                    end
                end else if (tb == 8'h22) begin
                    inkey = 1'b0; ph = PH_STRING;
                end else if (tb == "-") begin
                    neg = 1'b1; acc = '0; ph = PH_NUM_SIGN;
                end else if (tb >= "0" && tb <= "9") begin
                    neg = 1'b0; acc = {29'd0, tb[3:0]};
                    ph = (tb == "0") ? PH_NUM_ZERO : PH_NUM_INT;
                end else if (tb == "t" || tb == "f" || tb == "n") begin
                    ph = (tb == "t") ? PH_LIT_T : (tb == "f") ? PH_LIT_F : PH_LIT_N;
                    li = 3'd1;
                    tcol = tc;
                end else begin
                    ph = PH_STOPPED; fe = ERR_VALUE; fc = tc;
                end
            end

            if (pop_go) begin
                kind = top;
                dep = dep - 1'b1;
                top = r_below;
                rs[n[0]] = mk(kind ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'h00, 32'd0,
                              ERR_EMPTY, ccol, dep);
                n = n + 2'd1;
                ph = PH_AFTER;
            end
        end

        // checks at end of text
        if (endp_go && ph != PH_STOPPED) begin
            unique case (ph)
                PH_DOC_START: begin
                    ph = PH_STOPPED; fe = ERR_EMPTY; fc = ccol;
                end
                PH_VALUE, PH_ARR_FIRST: begin
                    ph = PH_STOPPED; fe = ERR_VALUE; fc = ccol;
                end
                PH_OBJ_FIRST, PH_OBJ_KEY: begin
                    ph = PH_STOPPED; fe = ERR_KEY; fc = ccol;
                end
                PH_COLON: begin
                    ph = PH_STOPPED; fe = ERR_COLON; fc = ccol;
                end
                PH_AFTER: begin
                    if (dep == '0) begin
                        rs[n[0]] = mk(EV_DOC_END, 8'h00, 32'd0, ERR_EMPTY, ccol, dep);
                        n = n + 2'd1;
                    end else begin
                        ph = PH_STOPPED; fe = top ? ERR_OBJ_SEP : ERR_ARR_SEP; fc = ccol;
                    end
                end
                PH_STRING: begin
                    ph = PH_STOPPED; fe = ERR_UNTERM; fc = ccol;
                end
                PH_ESCAPE: begin
                    ph = PH_STOPPED; fe = ERR_ESCAPE; fc = ccol;
                end
                PH_LIT_T, PH_LIT_F, PH_LIT_N: begin
                    ph = PH_STOPPED; fe = ERR_VALUE; fc = tcol;
                end
                default: ;
            endcase
        end

        // a failure is always the final result of its item
        if (ph == PH_STOPPED && r_ph != PH_STOPPED) begin
            rs[n[0]] = mk(EV_ERROR, 8'h00, 32'd0, fe, fc, dep);
            n = n + 2'd1;
            cm = CM_NONE;
        end

        if (n == 2'd1) rs[0].last = 1'b1;
        else if (n == 2'd2) rs[1].last = 1'b1;

        if (eot) begin
            ph = PH_DOC_START; dep = '0; acc = '0; neg = 1'b0; li = '0;
            bpos = '0; inkey = 1'b0; cm = CM_NONE; tcol = '0;
        end

        n_ph = ph; n_cm = cm; n_dep = dep; n_acc = acc; n_neg = neg; n_li = li;
        n_bpos = bpos; n_tcol = tcol; n_inkey = inkey; n_top = top;
        n_res0 = rs[0]; n_res1 = rs[1];
        n_cnt = n;
    end

    assign o_res0 = n_res0;
    assign o_res1 = n_res1;
    assign o_nres = i_acc ? n_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph    <= PH_DOC_START;
            r_cm    <= CM_NONE;
            r_dep   <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_li    <= '0;
            r_bpos  <= '0;
            r_tcol  <= '0;
            r_inkey <= 1'b0;
            r_top   <= 1'b0;
        end else if (i_acc) begin
            r_ph    <= n_ph;
            r_cm    <= n_cm;
            r_dep   <= n_dep;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_li    <= n_li;
            r_bpos  <= n_bpos;
            r_tcol  <= n_tcol;
            r_inkey <= n_inkey;
            r_top   <= n_top;
        end
    end

    // entry below the top is prefetched so a pop can restore it at once
    assign w_rd_dep = (i_acc ? n_dep : r_dep) - DW'(2);

    always_ff @(posedge i_clk) begin
        if (i_acc && n_push) begin
            r_stack[r_dep[AW-1:0]] <= n_kind;
        end
        r_below <= r_stack[w_rd_dep[AW-1:0]];
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import jsv_pkg::*;

    localparam longint unsigned COL_SAT = 64'hFFFF_FFFF;
    localparam int STACK_MAX = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [3:0]  ev;
        logic [7:0]  ch;
        logic [31:0] ival;
        logic [3:0]  err;
        logic [31:0] col;
        logic [6:0]  dep;
        logic        last;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tlast;

    json_stream_validator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    t_phase           ph;
    t_cmode           cm;
    bit               stk [STACK_MAX];
    int unsigned      depth;
    longint unsigned  accum;
    bit               neg;
    int unsigned      lit_idx;
    longint unsigned  pos;
    bit               in_key;
    longint unsigned  tok_col;
    longint unsigned  cur_col;
    bit               skip_comments;
    t_event           step_events[$];
    t_event           pending_events[$];

    function automatic longint unsigned col_inc(longint unsigned x);
        return (x >= COL_SAT) ? COL_SAT : x + 1;
    endfunction

    function automatic bit is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic void put_event(logic [3:0] ev, logic [7:0] ch, logic [31:0] iv,
                                      logic [3:0] err, longint unsigned col);
        t_event e;
        if (step_events.size() >= 4) return;
        e.ev = ev; e.ch = ch; e.ival = iv; e.err = err;
        e.col = (col > COL_SAT) ? 32'hFFFF_FFFF : col[31:0];
        e.dep = depth[6:0];
        e.last = 1'b0;
        step_events.push_back(e);
    endfunction

    function automatic void raise(logic [3:0] err, longint unsigned col);
        put_event(EV_ERROR, 8'h00, 32'h0, err, col);
        ph = PH_STOPPED;
        cm = CM_NONE;
    endfunction

    function automatic bit top_is_obj();
        return (depth > 0 && depth <= STACK_MAX) ? stk[depth-1] : 1'b0;
    endfunction

    function automatic void open_container(bit is_obj, longint unsigned col);
        if (depth >= STACK_MAX) begin
            raise(ERR_DEPTH, col);
            return;
        end
        stk[depth] = is_obj;
        depth++;
        put_event(is_obj ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h00, 32'h0, 4'h0, cur_col);
        ph = is_obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
    endfunction

    function automatic void close_container();
        bit is_obj;
        is_obj = top_is_obj();
        if (depth > 0) depth--;
        put_event(is_obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'h00, 32'h0, 4'h0, cur_col);
        ph = PH_AFTER;
    endfunction

    function automatic void begin_value(logic [7:0] b, longint unsigned col);
        if (b == "{") open_container(1'b1, col);
        else if (b == "[") open_container(1'b0, col);
        else if (b == "\"") begin
            in_key = 1'b0;
            ph = PH_STRING;
        end else if (b == "-") begin
            neg = 1'b1; accum = 0; ph = PH_NUM_SIGN;
        end else if (is_dig(b)) begin
            neg = 1'b0;
            accum = b - "0";
            ph = (b == "0") ? PH_NUM_ZERO : PH_NUM_INT;
        end else if (b == "t" || b == "f" || b == "n") begin
            ph = (b == "t") ? PH_LIT_T : (b == "f") ? PH_LIT_F : PH_LIT_N;
            lit_idx = 1;
            tok_col = col;
        end else raise(ERR_VALUE, col);
    endfunction

    function automatic void structural(logic [7:0] b, longint unsigned col);
        case (ph)
            PH_DOC_START, PH_VALUE: begin_value(b, col);
            PH_ARR_FIRST: if (b == "]") close_container(); else begin_value(b, col);
            PH_OBJ_FIRST: begin
                if (b == "}") close_container();
                else if (b == "\"") begin in_key = 1'b1; ph = PH_STRING; end
                else raise(ERR_KEY, col);
            end
            PH_OBJ_KEY: begin
                if (b == "\"") begin in_key = 1'b1; ph = PH_STRING; end
                else raise(ERR_KEY, col);
            end
            PH_COLON: if (b == ":") ph = PH_VALUE; else raise(ERR_COLON, col_inc(col));
            PH_AFTER: begin
                if (depth == 0) raise(ERR_TRAILING, col);
                else if (top_is_obj()) begin
                    if (b == "}") close_container();
                    else if (b == ",") ph = PH_OBJ_KEY;
                    else raise(ERR_OBJ_SEP, col_inc(col));
                end else begin
                    if (b == "]") close_container();
                    else if (b == ",") ph = PH_VALUE;
                    else raise(ERR_ARR_SEP, col_inc(col));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void between_tokens(logic [7:0] b, longint unsigned col);
        if ((b >= 8'h09 && b <= 8'h0D) || b == 8'h20) return;
        if (b == "/" && skip_comments) begin
            cm = CM_SLASH;
            tok_col = col;
            return;
        end
        structural(b, col);
    endfunction

    function automatic bit close_int(longint unsigned col);
        longint unsigned lim;
        longint unsigned v;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (accum > lim) begin
            raise(ERR_RANGE, col);
            return 1'b0;
        end
        v = neg ? (0 - accum) : accum;
        put_event(EV_INT, 8'h00, v[31:0], 4'h0, cur_col);
        ph = PH_AFTER;
        return 1'b1;
    endfunction

    function automatic void close_float();
        put_event(EV_FLOAT_END, 8'h00, 32'h0, 4'h0, cur_col);
        ph = PH_AFTER;
    endfunction

    function automatic void number_char(logic [7:0] b, longint unsigned col);
        bit e_mark;
        e_mark = (b == "e" || b == "E");
        case (ph)
            PH_NUM_SIGN: begin
                if (b == "0") ph = PH_NUM_ZERO;
                else if (is_dig(b)) begin accum = b - "0"; ph = PH_NUM_INT; end
                else raise(ERR_NUMBER, col);
            end
            PH_NUM_ZERO, PH_NUM_INT: begin
                if (is_dig(b)) begin
                    if (ph == PH_NUM_ZERO) raise(ERR_NUMBER, col);
                    else begin
                        accum = accum * 10 + (b - "0");
                        // clamp keeps the accumulator bounded; anything above is out of range
                        if (accum > 64'h1_0000_0000) accum = 64'h1_0000_0000;
                    end
                end else if (b == ".") ph = PH_NUM_DOT;
                else if (e_mark) ph = PH_NUM_EXP;
                else if (close_int(col)) between_tokens(b, col);
            end
            PH_NUM_DOT: if (is_dig(b)) ph = PH_NUM_FRAC; else raise(ERR_NUMBER, col);
            PH_NUM_FRAC: begin
                if (is_dig(b)) ;
                else if (e_mark) ph = PH_NUM_EXP;
                else begin close_float(); between_tokens(b, col); end
            end
            PH_NUM_EXP: begin
                if (b == "+" || b == "-") ph = PH_NUM_EXP_SIGN;
                else if (is_dig(b)) ph = PH_NUM_EXP_DIG;
                else raise(ERR_NUMBER, col);
            end
            PH_NUM_EXP_SIGN: if (is_dig(b)) ph = PH_NUM_EXP_DIG; else raise(ERR_NUMBER, col);
            default: begin
                if (!is_dig(b)) begin close_float(); between_tokens(b, col); end
            end
        endcase
    endfunction

    function automatic void string_char(logic [7:0] b, longint unsigned col);
        logic [7:0] c;
        if (ph == PH_ESCAPE) begin
            case (b)
                "\"": c = "\"";
                "\\": c = "\\";
                "/":  c = "/";
                "b":  c = 8'h08;
                "f":  c = 8'h0C;
                "n":  c = 8'h0A;
                "r":  c = 8'h0D;
                "t":  c = 8'h09;
                "u": begin raise(ERR_UNICODE, col_inc(col)); return; end
                default: begin raise(ERR_ESCAPE, col_inc(col)); return; end
            endcase
            put_event(in_key ? EV_KEY_CHAR : EV_STR_CHAR, c, 32'h0, 4'h0, cur_col);
            ph = PH_STRING;
            return;
        end
        if (b == "\"") begin
            put_event(in_key ? EV_KEY_END : EV_STR_END, 8'h00, 32'h0, 4'h0, cur_col);
            ph = in_key ? PH_COLON : PH_AFTER;
        end else if (b == "\\") ph = PH_ESCAPE;
        else if (b < CTRL_LIMIT) raise(ERR_CONTROL, col_inc(col));
        else put_event(in_key ? EV_KEY_CHAR : EV_STR_CHAR, b, 32'h0, 4'h0, cur_col);
    endfunction

    function automatic void word_char(logic [7:0] b);
        string word;
        int unsigned kind;
        kind = (ph == PH_LIT_T) ? 0 : (ph == PH_LIT_F) ? 1 : 2;
        word = (kind == 0) ? "true" : (kind == 1) ? "false" : "null";
        if (lit_idx >= word.len() || b != word[lit_idx]) begin
            raise(ERR_VALUE, tok_col);
            return;
        end
        lit_idx++;
        if (lit_idx < word.len()) return;
        if (kind == 2) begin raise(ERR_NULL, tok_col); return; end
        put_event(kind == 0 ? EV_TRUE : EV_FALSE, 8'h00, 32'h0, 4'h0, cur_col);
        ph = PH_AFTER;
    endfunction

    function automatic void close_document(longint unsigned col);
        case (ph)
            PH_NUM_ZERO, PH_NUM_INT: if (!close_int(col)) return;
            PH_NUM_FRAC, PH_NUM_EXP_DIG: close_float();
            PH_NUM_SIGN, PH_NUM_DOT, PH_NUM_EXP, PH_NUM_EXP_SIGN: begin
                raise(ERR_NUMBER, col);
                return;
            end
            default: ;
        endcase
        case (ph)
            PH_DOC_START: raise(ERR_EMPTY, col);
            PH_VALUE, PH_ARR_FIRST: raise(ERR_VALUE, col);
            PH_OBJ_FIRST, PH_OBJ_KEY: raise(ERR_KEY, col);
            PH_COLON: raise(ERR_COLON, col);
            PH_AFTER: begin
                if (depth == 0) put_event(EV_DOC_END, 8'h00, 32'h0, 4'h0, cur_col);
                else raise(top_is_obj() ? ERR_OBJ_SEP : ERR_ARR_SEP, col);
            end
            PH_STRING: raise(ERR_UNTERM, col);
            PH_ESCAPE: raise(ERR_ESCAPE, col);
            PH_LIT_T, PH_LIT_F, PH_LIT_N: raise(ERR_VALUE, tok_col);
            default: ;
        endcase
    endfunction

    function automatic void clear_document();
        ph = PH_DOC_START;
        depth = 0;
        accum = 0;
        neg = 1'b0;
        lit_idx = 0;
        pos = 0;
        in_key = 1'b0;
        cm = CM_NONE;
        tok_col = 0;
    endfunction

    function automatic void predict_events(logic eot, logic [7:0] b);
        longint unsigned col;
        step_events.delete();
        if (eot || b == 8'h00) begin
            col = col_inc(pos);
            cur_col = col;
            if (ph != PH_STOPPED) begin
                if (cm == CM_SLASH) begin
                    cm = CM_NONE;
                    structural("/", tok_col);
                end else if (cm == CM_BLOCK || cm == CM_STAR) raise(ERR_COMMENT, col);
                else cm = CM_NONE;
                if (ph != PH_STOPPED) close_document(col);
            end
            clear_document();
        end else begin
            pos = col_inc(pos);
            col = pos;
            cur_col = col;
            if (ph == PH_STOPPED) return;
            if (cm != CM_NONE) begin
                case (cm)
                    CM_SLASH: begin
                        if (b == "/") cm = CM_LINE;
                        else if (b == "*") cm = CM_BLOCK;
                        else begin
                            // not a comment after all: the slash is a token
                            cm = CM_NONE;
                            structural("/", tok_col);
                        end
                    end
                    CM_LINE: if (b == 8'h0A) cm = CM_NONE;
                    CM_BLOCK: if (b == "*") cm = CM_STAR;
                    default: begin
                        if (b == "/") cm = CM_NONE;
                        else if (b != "*") cm = CM_BLOCK;
                    end
                endcase
            end else if (ph == PH_STRING || ph == PH_ESCAPE) string_char(b, col);
            else if (ph == PH_LIT_T || ph == PH_LIT_F || ph == PH_LIT_N) word_char(b);
            else if (ph inside {PH_NUM_SIGN, PH_NUM_ZERO, PH_NUM_INT, PH_NUM_DOT, PH_NUM_FRAC,
                                PH_NUM_EXP, PH_NUM_EXP_SIGN, PH_NUM_EXP_DIG})
                number_char(b, col);
            else between_tokens(b, col);
        end
        if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
        foreach (step_events[i]) pending_events.push_back(step_events[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stream driver, receiver and checker
    // ------------------------------------------------------------------
    logic [8:0] byte_queue[$];   // {end of text, byte}
    logic [8:0] held;
    int send_idle = 0;
    int recv_idle = 0;
    int n_bytes = 0;
    int n_events = 0;
    int n_fail = 0;
    int cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_events(held[8], held[7:0]);
                n_bytes++;
            end
            if (!s_tvalid || s_tready) begin
                if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    held = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= held[8];
                    s_tdata <= held[7:0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && m_tvalid && m_tready) begin
            n_events++;
            if (pending_events.size() == 0) begin
                $error("event transfer with none expected: event %0d", m_tdata[3:0]);
                n_fail++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_res", want.ev, m_tdata[3:0]);
                check_field("char_value", want.ch, m_tdata[11:4]);
                check_field("int_value", want.ival, m_tdata[43:12]);
                check_field("error_code", want.err, m_tdata[47:44]);
                check_field("column", want.col, m_tdata[79:48]);
                check_field("nest_depth", want.dep, m_tdata[86:80]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Document generation
    // ------------------------------------------------------------------
    logic [7:0] doc[$];

    function automatic void add_text(string s);
        foreach (s[i]) doc.push_back(s[i]);
    endfunction

    function automatic void add_gap();
        case ($urandom_range(9))
            0: add_text(" ");
            1: doc.push_back(8'h0A);
            2: doc.push_back(8'h09);
            3: doc.push_back(8'($urandom_range(8'h0B, 8'h0D)));
            4: add_text("/*c**/");
            5: begin add_text("//n"); doc.push_back(8'h0A); end
            default: ;
        endcase
    endfunction

    function automatic void add_string();
        int n;
        n = $urandom_range(0, 4);
        add_text("\"");
        repeat (n) begin
            case ($urandom_range(5))
                0: begin
                    add_text("\\");
                    case ($urandom_range(7))
                        0: add_text("\""); 1: add_text("\\"); 2: add_text("/");
                        3: add_text("b");  4: add_text("f");  5: add_text("n");
                        6: add_text("r");  default: add_text("t");
                    endcase
                end
                1: doc.push_back(8'($urandom_range(8'h80, 8'hFF)));
                default: begin
                    logic [7:0] c;
                    c = 8'($urandom_range(8'h20, 8'h7E));
                    if (c == "\"" || c == "\\") c = "a";
                    doc.push_back(c);
                end
            endcase
        end
        add_text("\"");
    endfunction

    function automatic void add_value(int lvl);
        longint v;
        int n;
        case ($urandom_range(lvl >= 3 ? 4 : 6))
            0: begin
                case ($urandom_range(3))
                    0: v = $urandom_range(9);
                    1: v = $urandom_range(99999);
                    2: v = -longint'($urandom());
                    default: v = longint'($urandom()) - 64'sd2147483648;
                endcase
                add_text($sformatf("%0d", v));
            end
            1: add_string();
            2: add_text($urandom_range(1) ? "true" : "false");
            3: begin
                if ($urandom_range(1)) add_text("-");
                add_text($sformatf("%0d.%0d", $urandom_range(99), $urandom_range(999)));
                if ($urandom_range(1))
                    add_text($sformatf("%s%0d", $urandom_range(1) ? "E-" : "e",
                                       $urandom_range(30)));
            end
            4: add_text($sformatf("%0de+%0d", $urandom_range(9), $urandom_range(9)));
            5: begin
                add_text("[");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if (i) add_text(",");
                    add_gap();
                    add_value(lvl + 1);
                    add_gap();
                end
                add_text("]");
            end
            default: begin
                add_text("{");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++) begin
                    if (i) add_text(",");
                    add_gap();
                    add_string();
                    add_gap();
                    add_text(":");
                    add_value(lvl + 1);
                end
                add_text("}");
            end
        endcase
    endfunction

    // Queues the document and its end-of-text transfer (sometimes a NUL byte).
    function automatic void queue_doc();
        foreach (doc[i]) byte_queue.push_back({1'b0, doc[i]});
        if ($urandom_range(7) == 0) byte_queue.push_back(9'h000);
        else byte_queue.push_back({1'b1, 8'($urandom())});
        doc.delete();
    endfunction

    function automatic void queue_text(string s);
        add_text(s);
        queue_doc();
    endfunction

    function automatic void queue_random_docs(int nbytes);
        int start;
        start = byte_queue.size();
        while (byte_queue.size() - start < nbytes) begin
            if ($urandom_range(1)) add_gap();
            add_value(0);
            if ($urandom_range(1)) add_gap();
            case ($urandom_range(7))
                // broken documents: a random byte, a cut, or a stray trailing byte
                0: if (doc.size() > 0)
                    doc[$urandom_range(doc.size() - 1)] = 8'($urandom_range(1, 255));
                1: if (doc.size() > 1) doc = doc[0:$urandom_range(doc.size() - 2)];
                2: doc.push_back(8'($urandom_range(1, 255)));
                default: ;
            endcase
            queue_doc();
        end
    endfunction

    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_queue.size() > 0 || s_tvalid || pending_events.size() > 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_comment_mode(bit on);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'd0; pwdata <= {31'h0, on};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        skip_comments = on;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    initial begin
        skip_comments = 1'b0;
        clear_document();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 28; recv_idle = 68;
        queue_text("{\"a\":[1,-2,true,false,0.5e+3]}");
        queue_text("");
        queue_text("nul");
        queue_text("[null]");
        queue_text("[1 2]");
        queue_text("{\"k\" 1}");
        queue_text("{1}");
        queue_text("2147483647");
        queue_text("-2147483648");
        queue_text("2147483648");
        queue_text("99999999999");
        queue_text("\"\\u0041\"");
        queue_text("\"\\q\"");
        queue_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        add_text("\"x"); doc.push_back(8'h1F); queue_doc();
        queue_text("\"open");
        queue_text("\"\\");
        queue_text("-");
        queue_text("01");
        queue_text("1.");
        queue_text("1e");
        queue_text("[]{}");
        queue_text("{\"a\":}");
        queue_text("/*c*/1");
        queue_text("tru");
        for (int i = 0; i < 65; i++) add_text("[");
        queue_doc();
        // objects and arrays interleaved so each close restores the right kind
        for (int i = 0; i < 6; i++) add_text("{\"\":[");
        add_text("1");
        for (int i = 0; i < 6; i++) add_text("]}");
        queue_doc();
        queue_random_docs(15);
        wait_idle();

        write_comment_mode(1'b1);
        send_idle = 68; recv_idle = 28;
        queue_text("//line\n[1]");
        queue_text("/*a**/{ }/**/");
        queue_text("/*open");
        queue_text("/*star*");
        queue_text("1/");
        queue_text("/");
        queue_text("[1/2]");
        queue_text("1//tail");
        queue_random_docs(20);
        wait_idle();

        write_comment_mode(1'b0);
        send_idle = 0; recv_idle = 0;
        queue_random_docs(25);
        wait_idle();

        write_comment_mode(1'b1);
        queue_random_docs(10);
        wait_idle();

        $display("Covered %0d input transfers and %0d event transfers over three stall mixes,",
                 n_bytes, n_events);
        $display("with comment skipping both off and on.");
        if (n_fail == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
